@@ hw/rtl/fp10_fp32_int_converter_assert.svh @@
// assertion macros for the fp10 converter
`ifndef FP10_FP32_INT_CONVERTER_ASSERT_SVH
`define FP10_FP32_INT_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
`define FP10C_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define FP10C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FP10C_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FP10C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/fp10c_pkg.sv @@
`default_nettype none

package fp10c_pkg;

  typedef enum logic [1:0] {
    MODE_FP32_TO_FP10 = 2'd0,
    MODE_FP10_TO_FP32 = 2'd1,
    MODE_INT_TO_FP10  = 2'd2,
    MODE_FP10_TO_INT  = 2'd3
  } mode_e;

  localparam logic [8:0]  FP10_INF      = 9'h1F0;
  localparam logic [7:0]  FP32_EXP_MIN  = 8'd113;
  localparam logic [7:0]  FP32_EXP_DEN  = 8'd132;
  localparam logic [7:0]  FP32_EXP_BIAS = 8'd127;
  localparam logic [7:0]  FP10_EXP_ADJ  = 8'd112;
  localparam logic [4:0]  FP10_EXP_INT  = 5'd19;
  localparam logic [31:0] INT_INVALID   = 32'h8000_0000;

  function automatic logic [15:0] fp32_to_fp10(logic [31:0] w);
    logic [15:0] sgn16;
    logic [7:0]  e;
    logic [7:0]  dsh;
    logic [4:0]  sh;
    logic [25:0] m;
    logic [25:0] mask;
    logic [25:0] rem;
    logic [25:0] half;
    logic [5:0]  q;
    logic [12:0] base;
    logic [12:0] mag;
    sgn16 = {{7{w[31]}}, 9'b0};
    e     = w[30:23];
    if (e == 8'hFF) begin
      return sgn16 | {7'b0, FP10_INF} | {15'b0, (w[22:0] != 23'b0)};
    end
    if (e == 8'h00) begin
      return sgn16;
    end
    m = {2'b0, 1'b1, w[22:0]};
    if (e >= FP32_EXP_MIN) begin
      sh   = 5'd19;
      base = 13'({e - FP32_EXP_MIN, 4'b0});
    end else begin
      dsh = FP32_EXP_DEN - e;
      if (dsh > 8'd25) begin
        return sgn16;
      end
      sh   = dsh[4:0];
      base = 13'd0;
    end
    q    = 6'(m >> sh);
    mask = (26'd1 << sh) - 26'd1;
    rem  = m & mask;
    half = 26'd1 << (sh - 5'd1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 6'd1;
    end
    mag = base + {7'b0, q};
    if (mag >= {4'b0, FP10_INF}) begin
      mag = {4'b0, FP10_INF};
    end
    return sgn16 | {7'b0, mag[8:0]};
  endfunction

  function automatic logic [31:0] fp10_to_fp32(logic [15:0] x);
    logic       sgn;
    logic [4:0] e;
    logic [3:0] f;
    sgn = x[15];
    e   = x[8:4];
    f   = x[3:0];
    if (e == 5'h1F) begin
      return {sgn, 8'hFF, 19'b0, f};
    end
    if (e != 5'h00) begin
      return {sgn, {3'b0, e} + FP10_EXP_ADJ, f, 19'b0};
    end
    // denormal: leading one becomes the hidden bit
    if (f[3]) begin
      return {sgn, 8'd112, f[2:0], 1'b0, 19'b0};
    end else if (f[2]) begin
      return {sgn, 8'd111, f[1:0], 2'b0, 19'b0};
    end else if (f[1]) begin
      return {sgn, 8'd110, f[0], 3'b0, 19'b0};
    end else if (f[0]) begin
      return {sgn, 8'd109, 23'b0};
    end
    return {sgn, 31'b0};
  endfunction

  function automatic logic [15:0] int_to_fp10(logic [31:0] n);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] sh_mag;
    logic [3:0]  p;
    logic [7:0]  ex;
    logic [31:0] w;
    neg = n[31];
    mag = neg ? (32'd0 - n) : n;
    if (mag == 32'd0) begin
      return 16'd0;
    end
    if (mag[31:16] != 16'd0) begin
      return {{7{neg}}, FP10_INF};
    end
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) begin
        p = 4'(i);
      end
    end
    sh_mag = mag << (5'd23 - {1'b0, p});
    ex     = {4'b0, p} + FP32_EXP_BIAS;
    w      = {neg, ex, sh_mag[22:0]};
    return fp32_to_fp10(w);
  endfunction

  function automatic logic [31:0] fp10_to_int(logic [15:0] x);
    logic        neg;
    logic [4:0]  e;
    logic [31:0] m;
    logic [31:0] mag;
    neg = x[15];
    e   = x[8:4];
    m   = {27'b0, 1'b1, x[3:0]};
    if (e == 5'h1F) begin
      return INT_INVALID;
    end
    if (e == 5'h00) begin
      return 32'd0;
    end
    if (e >= FP10_EXP_INT) begin
      mag = m << (e - FP10_EXP_INT);
    end else begin
      mag = m >> (FP10_EXP_INT - e);
    end
    return neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fp10c_convert.sv @@
`default_nettype none

module fp10c_convert
  import fp10c_pkg::*;
(
  input  var logic [1:0]  mode_i,
  input  var logic [31:0] operand_i,
  output logic     [31:0] result_o
);

  mode_e mode;

  assign mode = mode_e'(mode_i);

  always_comb begin
    unique case (mode)
      MODE_FP32_TO_FP10: result_o = {16'b0, fp32_to_fp10(operand_i)};
      MODE_FP10_TO_FP32: result_o = fp10_to_fp32(operand_i[15:0]);
      MODE_INT_TO_FP10:  result_o = {16'b0, int_to_fp10(operand_i)};
      MODE_FP10_TO_INT:  result_o = fp10_to_int(operand_i[15:0]);
      default:           result_o = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/fp10_fp32_int_converter.sv @@
// channel | valid       | stall       | payload
// --------+-------------+-------------+--------------------
// in      | in_valid_i  | in_stall_o  | mode_i, operand_i
// out     | out_valid_o | out_stall_i | result_o
//
// two register stages: input register, then conversion logic into the result register
// one item per cycle while out_stall_i is low; out_valid_o flags result_q as valid
// reset clears both stage valid bits; payload registers are not reset
// in_stall_o rises only when both stages hold an item and out_stall_i is high
`default_nettype none

module fp10_fp32_int_converter
  import fp10c_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output logic            in_stall_o,
  input  var logic [1:0]  mode_i,
  input  var logic [31:0] operand_i,
  output logic            out_valid_o,
  input  var logic        out_stall_i,
  output logic     [31:0] result_o
);

  logic        in_vld_q;
  logic [1:0]  mode_q;
  logic [31:0] operand_q;
  logic        out_vld_q;
  logic [31:0] result_q;
  logic [31:0] result_d;
  logic        adv_out;
  logic        adv_in;

  assign adv_out    = !out_vld_q || !out_stall_i;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_stall_o = !adv_in;

  fp10c_convert u_convert (
    .mode_i    (mode_q),
    .operand_i (operand_q),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= in_valid_i;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      mode_q    <= mode_i;
      operand_q <= operand_i;
    end
    if (adv_out && in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = result_q;

`include "fp10_fp32_int_converter_assert.svh"

  `FP10C_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o,
    in_vld_q && out_vld_q && out_stall_i, "stall without a full pipe")
  `FP10C_ASSERT_NEXT(a_item_moves, clk_i, rst_ni, in_vld_q && adv_out,
    out_vld_q, "item lost between stages")
  `FP10C_ASSERT_NEXT(a_fp10_upper, clk_i, rst_ni,
    in_vld_q && adv_out && (mode_q == MODE_FP32_TO_FP10 || mode_q == MODE_INT_TO_FP10),
    result_q[31:16] == 16'd0, "fp10 result upper bits set")

endmodule

`default_nettype wire
